### hdl/updt_pkg.sv
// shared types, codes and widths for the udp port dispatch table
// no dependencies; imported by every other file of the block
package updt_pkg;

    localparam int CMD_W    = 2;
    localparam int PORT_W   = 16;
    localparam int HID_W    = 8;
    localparam int STATUS_W = 3;

    localparam int DEF_ENTRIES       = 16;
    localparam int DEF_HANDLER_WIDTH = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEREGISTER = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_dp_status;

endpackage

### hdl/updt_ifs.sv
// request and response channel interfaces of the udp port dispatch table
// depends on updt_pkg for field widths
interface updt_req_if
    import updt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PORT_W-1:0] port;
    logic [HID_W-1:0]  handler_id;

    modport source (output valid, output command, output port, output handler_id,
                    input ready);
    modport sink   (input valid, input command, input port, input handler_id,
                    output ready);
endinterface

interface updt_rsp_if
    import updt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HID_W-1:0]    found_handler;

    modport source (output valid, output status, output found_handler, input ready);
    modport sink   (input valid, input status, input found_handler, output ready);
endinterface

### hdl/updt_ctrl.sv
// sequencing state machine: accept, scan, commit and response handshake
// depends on updt_pkg for the command and status structs
module updt_ctrl
    import updt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic       i_rsp_ready,
    output logic       o_rsp_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_req_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FINISH) && (!r_out_valid || i_rsp_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.finish) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // response register: a new result may load as the old one leaves
    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

### hdl/updt_datapath.sv
// slot memory, valid bits, scan pipeline, result logic and response payload
// depends on updt_pkg for codes, widths and the command and status structs
module updt_datapath
    import updt_pkg::*;
#(
    parameter int ENTRIES       = DEF_ENTRIES,
    parameter int HANDLER_WIDTH = DEF_HANDLER_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [PORT_W-1:0]   i_port,
    input  logic [HID_W-1:0]    i_handler_id,
    output logic [STATUS_W-1:0] o_status_code,
    output logic [HID_W-1:0]    o_found_handler
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

    logic [PORT_W-1:0]        mem_port    [ENTRIES];
    logic [HANDLER_WIDTH-1:0] mem_handler [ENTRIES];
    logic [ENTRIES-1:0]       r_valid;

    // captured request
    logic [CMD_W-1:0]         r_cmd;
    logic [PORT_W-1:0]        r_port;
    logic [HANDLER_WIDTH-1:0] r_h;
    logic [HANDLER_WIDTH-1:0] h_in;

    // scan pipeline
    logic [CW-1:0]            r_cnt;
    logic                     r_pend;
    logic                     issue;
    logic [PORT_W-1:0]        r_rd_port;
    logic [HANDLER_WIDTH-1:0] r_rd_h;
    logic                     r_rd_valid;
    logic [AW-1:0]            r_rd_idx;

    // scan findings
    logic                     r_hit;
    logic [AW-1:0]            r_hit_idx;
    logic [HANDLER_WIDTH-1:0] r_hit_h;
    logic                     r_free;
    logic [AW-1:0]            r_free_idx;

    // result
    logic [STATUS_W-1:0]      res_status;
    logic [HID_W-1:0]         res_found;
    logic                     do_write;
    logic                     do_clear;
    logic [HID_W-1:0]         hit_h_out;

    always_comb begin
        for (int i = 0; i < HANDLER_WIDTH; i++) begin
            h_in[i] = (i < HID_W) ? i_handler_id[i] : 1'b0;
        end
        for (int j = 0; j < HID_W; j++) begin
            hit_h_out[j] = (j < HANDLER_WIDTH) ? r_hit_h[j] : 1'b0;
        end
    end

    assign issue = i_cmd.scan && (r_cnt < LAST_CNT);
    assign o_status.scan_done = i_cmd.scan && (r_cnt == LAST_CNT) && !r_pend;

    always_comb begin
        res_status = ST_INVALID;
        res_found  = '0;
        do_write   = 1'b0;
        do_clear   = 1'b0;
        if (r_port != '0) begin
            case (r_cmd)
                CMD_LOOKUP: begin
                    if (r_hit) begin
                        res_status = ST_OK;
                        res_found  = hit_h_out;
                    end else begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                CMD_REGISTER: begin
                    if (r_hit) begin
                        res_status = (r_hit_h == r_h) ? ST_OK : ST_CONFLICT;
                    end else if (r_free) begin
                        res_status = ST_OK;
                        do_write   = 1'b1;
                    end else begin
                        res_status = ST_FULL;
                    end
                end
                CMD_DEREGISTER: begin
                    if (r_hit) begin
                        res_status = ST_OK;
                        do_clear   = 1'b1;
                    end else begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    res_status = ST_INVALID;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else if (i_cmd.load) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) r_cnt <= r_cnt + 1'b1;
            end
            if (r_pend) begin
                if (r_rd_valid && (r_rd_port == r_port) && !r_hit) r_hit <= 1'b1;
                if (!r_rd_valid && !r_free) r_free <= 1'b1;
            end
            if (i_cmd.finish && do_write) r_valid[r_free_idx] <= 1'b1;
            if (i_cmd.finish && do_clear) r_valid[r_hit_idx] <= 1'b0;
        end
    end

    // payload registers and slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_port <= i_port;
            r_h    <= h_in;
        end
        if (issue) begin
            r_rd_port  <= mem_port[r_cnt[AW-1:0]];
            r_rd_h     <= mem_handler[r_cnt[AW-1:0]];
            r_rd_valid <= r_valid[r_cnt[AW-1:0]];
            r_rd_idx   <= r_cnt[AW-1:0];
        end
        if (r_pend && r_rd_valid && (r_rd_port == r_port) && !r_hit) begin
            r_hit_idx <= r_rd_idx;
            r_hit_h   <= r_rd_h;
        end
        if (r_pend && !r_rd_valid && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.finish && do_write) begin
            mem_port[r_free_idx]    <= r_port;
            mem_handler[r_free_idx] <= r_h;
        end
        if (i_cmd.finish) begin
            o_status_code   <= res_status;
            o_found_handler <= res_found;
        end
    end

endmodule

### hdl/udp_port_dispatch_table.sv
// udp port dispatch table: one request at a time, one response per request
// a new request is taken only once the previous one has finished its one-slot-a-cycle memory scan
// the next request is taken while the previous response waits in the output register
// reset (synchronous, active low) empties every slot at once through per-slot valid bits
module udp_port_dispatch_table
    import updt_pkg::*;
#(
    parameter int ENTRIES       = DEF_ENTRIES,
    parameter int HANDLER_WIDTH = DEF_HANDLER_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    updt_req_if.sink   i_req,
    updt_rsp_if.source o_rsp
);

    // command and status between the state machine and the datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller: idle -> scan (one slot per cycle) -> finish (commit and respond)
    updt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // datapath: slot memory with valid bits, scan for first match and first
    // empty slot, then decide status and update the table in the finish cycle
    updt_datapath #(
        .ENTRIES       (ENTRIES),
        .HANDLER_WIDTH (HANDLER_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_req.command),
        .i_port          (i_req.port),
        .i_handler_id    (i_req.handler_id),
        .o_status_code   (o_rsp.status),
        .o_found_handler (o_rsp.found_handler)
    );

`ifndef SYNTH
    // one request at a time: no acceptance right after a transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // a handler number only comes back with an ok status
    a_found_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.found_handler == '0))
        else $error("found handler nonzero on a failing status");

    // a response is loaded only when the scan has finished
    a_commit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |-> ($past(dp_status.scan_done) || !dp_cmd.scan))
        else $error("commit without a completed scan");
`endif

endmodule

### tb/tb.sv
// self-checking testbench for udp_port_dispatch_table: directed table walk, then random traffic
// depends on updt_pkg, updt_req_if / updt_rsp_if and the udp_port_dispatch_table rtl
module tb;
    import updt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 20;
    localparam int N_SLOTS    = DEF_ENTRIES;
    // drain wait after the expectation queue empties, derived from the table depth
    localparam int DRAIN_CYCLES = N_SLOTS + 3 + 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int N_RANDOM     = 900;
    localparam int POOL_N       = 32;
    localparam int N_DIR        = 29;
    // the fourth command encoding has no meaning and must come back with the invalid status
    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HID_W-1:0]    found;
    } t_dispatch_rsp;

    // one directed transaction; typed set means the response is written out in the row
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [PORT_W-1:0]   port;
        logic [HID_W-1:0]    hid;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [HID_W-1:0]    found;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    updt_req_if req_if ();
    updt_rsp_if rsp_if ();

    udp_port_dispatch_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the port table, updated as each request is accepted
    logic [PORT_W-1:0] shadow_port [N_SLOTS];
    logic [HID_W-1:0]  shadow_hid  [N_SLOTS];

    t_dispatch_rsp expected_rsp_q [$];
    t_dispatch_rsp head_rsp;
    int err_cnt   = 0;
    int rsp_cnt   = 0;
    int cycle_cnt = 0;

    // ports the random part draws from: one-hot ports match the directed fill, the rest random
    logic [PORT_W-1:0] port_pool [POOL_N];
    logic [HID_W-1:0]  hid_pool  [POOL_N];

    // directed walk: invalid ports, an undefined command, misses, same and different rebinding, fill until full,
    // free one slot and reuse it
    t_dir_row dir_rows [N_DIR] = '{
        '{CMD_LOOKUP,     16'h0001, 8'h00, 1'b1, ST_NOT_FOUND, 8'h00},
        '{CMD_LOOKUP,     16'h0000, 8'h00, 1'b1, ST_INVALID,   8'h00},
        '{CMD_REGISTER,   16'h0000, 8'hFF, 1'b1, ST_INVALID,   8'h00},
        '{CMD_DEREGISTER, 16'h0000, 8'h00, 1'b1, ST_INVALID,   8'h00},
        '{CMD_UNDEF,      16'h1234, 8'hAA, 1'b1, ST_INVALID,   8'h00},
        '{CMD_DEREGISTER, 16'hFFFF, 8'h00, 1'b1, ST_NOT_FOUND, 8'h00},
        '{CMD_REGISTER,   16'hFFFF, 8'hFF, 1'b1, ST_OK,        8'h00},
        '{CMD_LOOKUP,     16'hFFFF, 8'h00, 1'b1, ST_OK,        8'hFF},
        '{CMD_REGISTER,   16'hFFFF, 8'hFF, 1'b1, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'hFFFF, 8'h00, 1'b1, ST_CONFLICT,  8'h00},
        '{CMD_REGISTER,   16'h0001, 8'h00, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0002, 8'h01, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0004, 8'h02, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0008, 8'h04, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0010, 8'h08, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0020, 8'h10, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0040, 8'h20, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0080, 8'h40, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0100, 8'h80, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0200, 8'h55, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0400, 8'hAA, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h0800, 8'h0F, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h1000, 8'hF0, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h2000, 8'h33, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h4000, 8'hCC, 1'b0, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h8000, 8'h5A, 1'b1, ST_FULL,      8'h00},
        '{CMD_DEREGISTER, 16'h0001, 8'h00, 1'b1, ST_OK,        8'h00},
        '{CMD_REGISTER,   16'h8000, 8'h5A, 1'b0, ST_OK,        8'h00},
        '{CMD_LOOKUP,     16'h8000, 8'h00, 1'b0, ST_OK,        8'h00}
    };

    // applies one request to the shadow table and returns the response it should produce
    function automatic t_dispatch_rsp apply_to_table(input logic [CMD_W-1:0] cmd,
                                                     input logic [PORT_W-1:0] port,
                                                     input logic [HID_W-1:0] hid);
        t_dispatch_rsp r;
        int hit;
        int empty;
        r.status = ST_INVALID;
        r.found  = '0;
        hit      = -1;
        empty    = -1;
        // walk downward so the lowest matching and lowest empty slot win
        for (int k = N_SLOTS - 1; k >= 0; k--) begin
            if (shadow_port[k] == port) hit = k;
            if (shadow_port[k] == '0) empty = k;
        end
        if (port != '0) begin
            case (cmd)
                CMD_LOOKUP: begin
                    if (hit >= 0) begin
                        r.status = ST_OK;
                        r.found  = shadow_hid[hit];
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                CMD_REGISTER: begin
                    if (hit >= 0) begin
                        r.status = (shadow_hid[hit] == hid) ? ST_OK : ST_CONFLICT;
                    end else if (empty >= 0) begin
                        shadow_port[empty] = port;
                        shadow_hid[empty]  = hid;
                        r.status           = ST_OK;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                CMD_DEREGISTER: begin
                    if (hit >= 0) begin
                        shadow_port[hit] = '0;
                        shadow_hid[hit]  = '0;
                        r.status         = ST_OK;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: r.status = ST_INVALID;
            endcase
        end
        return r;
    endfunction

    // offers one request from a falling edge, holds it until accepted, returns at the next
    // falling edge with valid still high
    task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                                 input logic [HID_W-1:0] hid, input logic typed,
                                 input t_dispatch_rsp typed_rsp);
        t_dispatch_rsp model_rsp;
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.port       <= port;
        req_if.handler_id <= hid;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // the shadow table follows every accepted transaction, typed rows too
        model_rsp = apply_to_table(cmd, port, hid);
        expected_rsp_q.push_back(typed ? typed_rsp : model_rsp);
        @(negedge i_clk);
    endtask

    // idle cycles between requests: calm stretches with none, mostly short gaps, a few long
    function automatic int pick_gap(input int idx);
        int r;
        r = $urandom_range(0, 99);
        if ((idx / 100) % 4 == 0) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // request side
    initial begin : stim
        logic [CMD_W-1:0]  cmd;
        logic [PORT_W-1:0] port;
        logic [HID_W-1:0]  hid;
        int r;
        int k;
        int gap;
        int reg_w;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_LOOKUP;
        req_if.port       = '0;
        req_if.handler_id = '0;
        for (int s = 0; s < N_SLOTS; s++) begin
            shadow_port[s] = '0;
            shadow_hid[s]  = '0;
        end
        for (int p = 0; p < POOL_N; p++) begin
            port_pool[p] = (p < 16) ? PORT_W'(1) << p : PORT_W'($urandom_range(1, 65535));
            hid_pool[p]  = HID_W'($urandom_range(0, 255));
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int d = 0; d < N_DIR; d++) begin
            offer_request(dir_rows[d].cmd, dir_rows[d].port, dir_rows[d].hid,
                          dir_rows[d].typed, '{dir_rows[d].status, dir_rows[d].found});
            gap = pick_gap(d + 100);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // alternate draining and filling phases so the table swings between empty and full
            reg_w = ((i / 150) % 2 == 0) ? 15 : 35;
            r     = $urandom_range(0, 99);
            if (r < 5) cmd = CMD_UNDEF;
            else if (r < 45) cmd = CMD_LOOKUP;
            else if (r < 45 + reg_w) cmd = CMD_REGISTER;
            else cmd = CMD_DEREGISTER;
            // pool ports give hits and rebinding, random ones give misses and every port bit
            k = $urandom_range(0, POOL_N - 1);
            r = $urandom_range(0, 99);
            if (r < 8) port = '0;
            else if (r < 28) port = PORT_W'($urandom_range(0, 65535));
            else port = port_pool[k];
            hid = ($urandom_range(0, 3) == 0) ? HID_W'($urandom_range(0, 255)) : hid_pool[k];
            offer_request(cmd, port, hid, 1'b0, '0);
            gap = pick_gap(i);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        req_if.valid <= 1'b0;

        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // response side: random stalls, calm stretches, and one long hold-off that backs the
    // block up until it refuses new requests
    initial begin : rsp_sink
        int stall_left;
        int hold_left;
        bit held;
        int r;
        stall_left   = 0;
        hold_left    = 0;
        held         = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && rsp_cnt >= 400) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if ((cycle_cnt / 200) % 3 == 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    rsp_if.ready <= 1'b1;
                end else if (r < 95) begin
                    rsp_if.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    rsp_if.ready <= 1'b0;
                    stall_left = $urandom_range(10, 60);
                end
            end
        end
    end

    // response checker: every accepted response against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_cnt++;
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: unexpected response, status %0d found_handler %0d",
                         $time, rsp_if.status, rsp_if.found_handler);
                err_cnt++;
            end else begin
                head_rsp = expected_rsp_q.pop_front();
                if (rsp_if.status !== head_rsp.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, head_rsp.status, rsp_if.status);
                    err_cnt++;
                end
                if (rsp_if.found_handler !== head_rsp.found) begin
                    $display("%0t: found_handler expected %0d, got %0d",
                             $time, head_rsp.found, rsp_if.found_handler);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule
